// ===== hdl/bpk_pkg.sv =====
package bpk_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned LenW    = 4;
    localparam int unsigned StatW   = 2;
    localparam int unsigned InDataW = 16;
    localparam int unsigned OutDataW = 16;
    localparam int unsigned OutUserW = 3;

    localparam logic [ByteW-1:0] ALL_ONES  = 8'hFF;
    localparam logic [LenW-1:0]  BYTE_BITS = 4'd8;

    localparam logic           FUNC_CODE = 1'b0;
    localparam logic           FUNC_RAW  = 1'b1;

    localparam logic [StatW-1:0] ST_OK      = 2'd0;
    localparam logic [StatW-1:0] ST_BAD_LEN = 2'd1;
    localparam logic [StatW-1:0] ST_WIDE    = 2'd2;

    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        logic             byte_valid;
        logic [StatW-1:0] status;
        logic [LenW-1:0]  free_bits;
        logic             last;
    } t_res;

    typedef struct packed {
        logic push;
        logic two;
        t_res res0;
        t_res res1;
    } t_push;

endpackage

// ===== hdl/msb_first_bit_packer_stuffing.sv =====
// Channel   Direction  Handshake                   Payload
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_data: stuff_enable
// input     in         s_axis_tvalid / tready      tdata, tuser, see ports
// result    out        m_axis_tvalid / tready      tdata, tuser, tlast, see ports
//
// One input transaction is taken per cycle while the queue has room; its one or two
// results are written to a four-entry result queue in the same cycle.
// An input that yields two results takes two queue entries, so the input
// side waits while fewer than two queue entries are free.
// Reset clears the packing state, the stuffing flag and the queue.
module msb_first_bit_packer_stuffing (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // code_value[7:0], code_length[11:8], zeros
    input  logic [bpk_pkg::InDataW-1:0]    s_axis_tdata,
    input  logic                           s_axis_tuser,   // func
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_byte[7:0], free_bits[11:8], zeros
    output logic [bpk_pkg::OutDataW-1:0]   m_axis_tdata,
    // byte_valid[0], status[2:1]
    output logic [bpk_pkg::OutUserW-1:0]   m_axis_tuser,
    output logic                           m_axis_tlast
);

    bpk_pkg::t_push push;
    bpk_pkg::t_res  res;
    logic           room;
    logic           accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    bpk_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_stuff   (i_cfg_data),
        .i_accept      (accept),
        .i_func        (s_axis_tuser),
        .i_code_value  (s_axis_tdata[7:0]),
        .i_code_length (s_axis_tdata[11:8]),
        .o_push        (push)
    );

    bpk_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = {4'd0, res.free_bits, res.out_byte};
    assign m_axis_tuser = {res.status, res.byte_valid};
    assign m_axis_tlast = res.last;

endmodule

// ===== hdl/bpk_core.sv =====
module bpk_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_stuff,
    input  logic                    i_accept,
    input  logic                    i_func,
    input  logic [bpk_pkg::ByteW-1:0] i_code_value,
    input  logic [bpk_pkg::LenW-1:0]  i_code_length,
    output bpk_pkg::t_push          o_push
);

    logic [bpk_pkg::ByteW-1:0] r_partial, n_partial;
    logic [bpk_pkg::LenW-1:0]  r_free, n_free;
    logic                      r_stuff;

    logic                      bad_len;
    logic                      wide;
    logic [bpk_pkg::LenW-1:0]  hang;
    logic [bpk_pkg::LenW-1:0]  fit;
    logic [bpk_pkg::LenW-1:0]  free_after;
    logic [bpk_pkg::ByteW-1:0] shifted;
    logic [bpk_pkg::ByteW-1:0] sum;
    logic [bpk_pkg::ByteW-1:0] padded;
    logic [bpk_pkg::ByteW-1:0] hang_mask;
    logic                      had;
    bpk_pkg::t_res             res0, res1;
    logic                      two;

    always_comb begin
        bad_len = (i_code_length == '0) || (i_code_length > bpk_pkg::BYTE_BITS);
        wide    = ((i_code_value >> i_code_length) != '0);
        hang    = (i_code_length > r_free) ? (i_code_length - r_free) : '0;
        fit     = i_code_length - hang;
        shifted = r_partial << fit;
        sum     = shifted + (i_code_value >> hang);
        free_after = r_free - fit;
        hang_mask  = 8'((9'd1 << hang) - 9'd1);
        had     = (r_free != bpk_pkg::BYTE_BITS);
        padded  = r_partial << r_free[2:0];

        n_partial = r_partial;
        n_free    = r_free;
        two       = 1'b0;
        res0      = '{out_byte: '0, byte_valid: 1'b0, status: bpk_pkg::ST_OK,
                      free_bits: r_free, last: 1'b1};
        res1      = '{out_byte: '0, byte_valid: 1'b1, status: bpk_pkg::ST_OK,
                      free_bits: r_free, last: 1'b1};

        if (i_func == bpk_pkg::FUNC_RAW) begin
            n_partial = '0;
            n_free    = bpk_pkg::BYTE_BITS;
            res1.out_byte  = i_code_value;
            res1.free_bits = bpk_pkg::BYTE_BITS;
            if (had) begin
                two = 1'b1;
                res0 = '{out_byte: padded, byte_valid: 1'b1, status: bpk_pkg::ST_OK,
                         free_bits: bpk_pkg::BYTE_BITS, last: 1'b0};
            end else begin
                res0 = res1;
            end
        end else if (bad_len) begin
            res0.status = bpk_pkg::ST_BAD_LEN;
        end else if (wide) begin
            res0.status = bpk_pkg::ST_WIDE;
        end else if (free_after != '0) begin
            n_partial = sum;
            n_free    = free_after;
            res0.free_bits = free_after;
        end else begin
            n_partial = i_code_value & hang_mask;
            n_free    = bpk_pkg::BYTE_BITS - hang;
            res0.out_byte   = sum;
            res0.byte_valid = 1'b1;
            res0.free_bits  = n_free;
            res1.free_bits  = n_free;
            if (r_stuff && (sum == bpk_pkg::ALL_ONES)) begin
                two = 1'b1;
                res0.last = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_free    <= bpk_pkg::BYTE_BITS;
            r_stuff   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_stuff <= i_cfg_stuff;
            end
            if (i_accept) begin
                r_partial <= n_partial;
                r_free    <= n_free;
            end
        end
    end

    assign o_push = '{push: i_accept, two: two, res0: res0, res1: res1};

endmodule

// ===== hdl/bpk_fifo.sv =====
module bpk_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bpk_pkg::t_push i_push,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_ready,
    output bpk_pkg::t_res  o_res
);

    bpk_pkg::t_res r_mem [4];
    logic [1:0] r_wptr, n_wptr;
    logic [1:0] r_rptr, n_rptr;
    logic [2:0] r_cnt, n_cnt;
    logic       r_room;
    logic       pop;
    logic [1:0] n_in;

    always_comb begin
        pop    = (r_cnt != 3'd0) && i_ready;
        n_in   = i_push.push ? (i_push.two ? 2'd2 : 2'd1) : 2'd0;
        n_wptr = r_wptr + n_in;
        n_rptr = r_rptr + {1'b0, pop};
        n_cnt  = r_cnt + {1'b0, n_in} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wptr] <= i_push.res0;
            if (i_push.two) begin
                r_mem[r_wptr + 2'd1] <= i_push.res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
            r_room <= 1'b0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
            r_room <= (n_cnt <= 3'd2);
        end
    end

    assign o_room  = r_room;
    assign o_valid = (r_cnt != 3'd0);
    assign o_res   = r_mem[r_rptr];

endmodule
